// ===== design/sha_pkg.sv =====
// Package for the SHA-256 compression block: payload types, round constants,
// schedule and round functions. No dependencies.
`default_nettype none
package sha_pkg;

  localparam int ROUND_COUNT = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int CHAIN_WORDS = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [31:0] message_word;
    logic        start_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] hash_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // one block handed from front to back
  typedef struct packed {
    logic [BLOCK_WORDS-1:0][31:0] words;
    logic                          reload;
    logic [CHAIN_WORDS-1:0][31:0] iv;
  } block_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } back_state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

  function automatic logic [CHAIN_WORDS-1:0][31:0] iv_reset();
    iv_reset = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
                32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

// ===== design/sha_front.sv =====
// Front end: takes message words, builds 16-word blocks, flags an IV reload on start.
// Uses sha_pkg.
`default_nettype none
module sha_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic [2:0]          wr_index,
  input  wire logic [31:0]         wr_data,
  input  wire sha_pkg::in_item_t   in_data,
  input  wire logic                in_valid,
  output      logic                in_stall,
  output      logic                blk_valid,
  output      sha_pkg::block_t     blk_data,
  input  wire logic                blk_stall
);

  logic [sha_pkg::CHAIN_WORDS-1:0][31:0] iv;
  logic [sha_pkg::BLOCK_WORDS-1:0][31:0] words;
  logic [3:0]  count;
  logic        reload;
  logic [3:0]  slot;
  logic        take;

  // a block waits here only if the queue is full; stall then
  assign in_stall = blk_valid && blk_stall;
  assign take     = in_valid && !in_stall;
  assign slot     = in_data.start_message ? 4'd0 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= sha_pkg::iv_reset();
    end else if (wr_en) begin
      iv[wr_index] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      words[slot] <= in_data.message_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      reload    <= 1'b0;
      blk_valid <= 1'b0;
    end else begin
      if (blk_valid && !blk_stall) begin
        blk_valid <= 1'b0;
      end
      if (take) begin
        count <= slot + 4'd1;
        if (in_data.start_message) begin
          reload <= 1'b1;
        end
        if (slot == 4'd15) begin
          blk_valid <= 1'b1;
        end
      end
      if (blk_valid && !blk_stall && !(take && in_data.start_message)) begin
        reload <= 1'b0;
      end
    end
  end

  // iv sampled at hand-off; the user must make config writes only while idle (not enforced here)
  always_comb begin
    blk_data.words  = words;
    blk_data.reload = reload;
    blk_data.iv     = iv;
  end

endmodule
`default_nettype wire

// ===== design/sha_queue.sv =====
// Two-entry block queue between front and back ends. Uses sha_pkg.
`default_nettype none
module sha_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  input  wire sha_pkg::block_t  wr_data,
  output      logic             wr_stall,
  output      logic             rd_valid,
  output      sha_pkg::block_t  rd_data,
  input  wire logic             rd_take
);

  sha_pkg::block_t mem [sha_pkg::QUEUE_DEPTH];
  logic       wptr, rptr;
  logic [1:0] fill;
  logic       push, pop;

  assign wr_stall = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_take && rd_valid;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== design/sha_back.sv =====
// Back end: schedule expansion, 64 rounds one per cycle, chain add, result beats.
// Uses sha_pkg.
`default_nettype none
module sha_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               blk_valid,
  input  wire sha_pkg::block_t    blk_data,
  output      logic               blk_take,
  output      logic               out_valid,
  output      sha_pkg::out_item_t out_data,
  input  wire logic               out_stall
);

  sha_pkg::back_state_t state, state_next;
  logic [sha_pkg::CHAIN_WORDS-1:0][31:0] chain, v;
  logic [sha_pkg::BLOCK_WORDS-1:0][31:0] w;
  logic [5:0]  rnd;
  logic [2:0]  idx;
  logic [31:0] t1, t2, e, a, w_new;

  assign e = v[4];
  assign a = v[0];
  assign t1 = v[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
            + ((e & v[5]) ^ (~e & v[6])) + sha_pkg::round_k(rnd) + w[0];
  assign t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
            + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  assign w_new = sha_pkg::small_s1(w[14]) + w[9] + sha_pkg::small_s0(w[1]) + w[0];

  always_comb begin
    state_next = state;
    blk_take   = 1'b0;
    case (state)
      sha_pkg::ST_IDLE: begin
        if (blk_valid) begin
          blk_take   = 1'b1;
          state_next = sha_pkg::ST_ROUND;
        end
      end
      sha_pkg::ST_ROUND: if (rnd == 6'd63) state_next = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD:   state_next = sha_pkg::ST_EMIT;
      sha_pkg::ST_EMIT:  if (!out_stall && idx == 3'd7) state_next = sha_pkg::ST_IDLE;
      default:           state_next = sha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      chain <= sha_pkg::iv_reset();
      rnd   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        sha_pkg::ST_IDLE: begin
          if (blk_valid) begin
            if (blk_data.reload) begin
              chain <= blk_data.iv;
              v     <= blk_data.iv;
            end else begin
              v <= chain;
            end
            w   <= blk_data.words;
            rnd <= '0;
          end
        end
        sha_pkg::ST_ROUND: begin
          for (int j = sha_pkg::CHAIN_WORDS - 1; j > 0; j--) v[j] <= v[j-1];
          v[4] <= v[3] + t1;
          v[0] <= t1 + t2;
          for (int j = 0; j < sha_pkg::BLOCK_WORDS - 1; j++) w[j] <= w[j+1];
          w[15] <= w_new;
          rnd <= rnd + 6'd1;
        end
        sha_pkg::ST_ADD: begin
          for (int j = 0; j < sha_pkg::CHAIN_WORDS; j++) chain[j] <= chain[j] + v[j];
          idx <= '0;
        end
        sha_pkg::ST_EMIT: if (!out_stall) idx <= idx + 3'd1;
        default: ;
      endcase
    end
  end

  assign out_valid           = (state == sha_pkg::ST_EMIT);
  assign out_data.hash_word  = chain[idx];
  assign out_data.word_index = idx;
  assign out_data.last_word  = (idx == 3'd7);

endmodule
`default_nettype wire

// ===== design/sha256_compression.sv =====
// SHA-256 compression top: front end, two-block queue, back end.
// The back end works on one block at a time: 64 rounds on one round unit, a chain add,
// eight result beats; it takes the next block from the queue only once back in idle.
// Synchronous active-high reset restores the standard IV and empties the queue.
`default_nettype none
module sha256_compression (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire sha_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      sha_pkg::out_item_t out_data
);

  logic            f_valid, f_stall, q_valid, q_take;
  sha_pkg::block_t f_data, q_data;

  sha_front u_front (
    .clk, .rst,
    .wr_en(cfg_wr_en), .wr_index(cfg_index), .wr_data(cfg_data),
    .in_data, .in_valid, .in_stall,
    .blk_valid(f_valid), .blk_data(f_data), .blk_stall(f_stall)
  );

  sha_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_data(f_data), .wr_stall(f_stall),
    .rd_valid(q_valid), .rd_data(q_data), .rd_take(q_take)
  );

  sha_back u_back (
    .clk, .rst,
    .blk_valid(q_valid), .blk_data(q_data), .blk_take(q_take),
    .out_valid, .out_data, .out_stall
  );

endmodule
`default_nettype wire
